@@ sv/cbdi_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cbdi_pkg - shared types and defaults of the convolutional byte deinterleaver
// Holds the default geometry, the output queue depth and the beat type that
// carries one byte between the pipeline stages.
// ----------------------------------------------------------------------------
package cbdi_pkg;

	localparam int BYTE_W          = 8;
	localparam int BRANCHES_DEF    = 52;
	localparam int DELAY_STEP_DEF  = 4;
	localparam int ALIGN_DEPTH_DEF = 156;
	localparam int OUTQ_DEPTH_DEF  = 8;

	// one byte moving down the pipeline, with its valid flag
	typedef struct packed {
		logic              vld;
		logic [BYTE_W-1:0] dat;
	} cbdi_beat_t;

endpackage
`default_nettype wire

@@ sv/cbdi_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cbdi_ram - generic simple dual-port RAM
// One write port and one read port, registered read data with read enable.
// A read and a write to the same address at the same edge return the old data.
// ----------------------------------------------------------------------------
module cbdi_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

@@ sv/cbdi_branch.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cbdi_branch - commutator and branch delay lines
// Pointer RAM holds each branch's position, store RAM holds all branch lines
// back to back. Per-branch flags stand in for the cleared reset contents.
// ----------------------------------------------------------------------------
module cbdi_branch #(
	parameter int BRANCHES   = cbdi_pkg::BRANCHES_DEF,
	parameter int DELAY_STEP = cbdi_pkg::DELAY_STEP_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      acc,
	input  wire logic [cbdi_pkg::BYTE_W-1:0] data_in,
	input  wire logic                      resync,
	output cbdi_pkg::cbdi_beat_t           beat
);
	import cbdi_pkg::*;

	localparam int CW     = (BRANCHES > 1) ? $clog2(BRANCHES) : 1;
	localparam int MAXLEN = (BRANCHES - 1) * DELAY_STEP;
	localparam int LW     = $clog2(MAXLEN + 1);
	localparam int SD     = (DELAY_STEP * BRANCHES * (BRANCHES - 1)) / 2;
	localparam int SAW    = (SD > 1) ? $clog2(SD) : 1;
	localparam int BW     = $clog2(SD + 1);

	// commutator with running base address and length of the current branch
	logic [CW-1:0] comm_q;
	logic [BW-1:0] base_q;
	logic [LW-1:0] len_q;
	logic [CW-1:0] c0;
	logic [BW-1:0] base0;
	logic [LW-1:0] len0;

	// stage 1
	logic              v_s1;
	logic [CW-1:0]     c_s1;
	logic [BW-1:0]     base_s1;
	logic [LW-1:0]     len_s1;
	logic [BYTE_W-1:0] dat_s1;

	// stage 2
	logic              v_s2;
	logic [CW-1:0]     c_s2;
	logic              nz_s2;
	logic [LW-1:0]     pn_s2;
	logic [BYTE_W-1:0] dat_s2;
	logic              fill_s2;

	logic [BRANCHES-1:0] pv_q;
	logic [BRANCHES-1:0] fill_q;

	logic [LW-1:0]     ptr_rdata;
	logic [LW-1:0]     p;
	logic [LW-1:0]     p_inc;
	logic [LW-1:0]     pn;
	logic              nz_s1;
	logic              fwd;
	logic              st_acc;
	logic [BW-1:0]     addr_full;
	logic [SAW-1:0]    st_addr;
	logic [BYTE_W-1:0] st_rdata;

	always_comb begin
		c0    = resync ? '0 : comm_q;
		base0 = resync ? '0 : base_q;
		len0  = resync ? LW'(MAXLEN) : len_q;
	end

	// advance the commutator and wrap after the last branch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			comm_q <= '0;
			base_q <= '0;
			len_q  <= LW'(MAXLEN);
		end else if (acc) begin
			if (c0 == CW'(BRANCHES - 1)) begin
				comm_q <= '0;
				base_q <= '0;
				len_q  <= LW'(MAXLEN);
			end else begin
				comm_q <= CW'(c0 + CW'(1));
				base_q <= BW'(base0 + BW'(len0));
				len_q  <= LW'(len0 - LW'(DELAY_STEP));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= acc;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		c_s1    <= c0;
		base_s1 <= base0;
		len_s1  <= len0;
		dat_s1  <= data_in;
		c_s2    <= c_s1;
		nz_s2   <= nz_s1;
		pn_s2   <= pn;
		dat_s2  <= dat_s1;
		fill_s2 <= fill_q[c_s1];
	end

	// forward the pointer written in the previous cycle for the same branch
	always_comb begin
		nz_s1     = (len_s1 != '0);
		fwd       = v_s2 && nz_s2 && (c_s2 == c_s1);
		if (fwd) begin
			p = pn_s2;
		end else begin
			p = pv_q[c_s1] ? ptr_rdata : '0;
		end
		p_inc     = LW'(p + LW'(1));
		pn        = (p_inc == len_s1) ? '0 : p_inc;
		st_acc    = v_s1 && nz_s1;
		addr_full = BW'(base_s1 + BW'(p));
		st_addr   = addr_full[SAW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_q   <= '0;
			fill_q <= '0;
		end else if (st_acc) begin
			pv_q[c_s1] <= 1'b1;
			if (pn == '0) begin
				fill_q[c_s1] <= 1'b1;
			end
		end
	end

	cbdi_ram #(
		.WIDTH (LW),
		.DEPTH (BRANCHES),
		.AW    (CW)
	) u_ptr_ram (
		.clk   (clk),
		.we    (st_acc),
		.waddr (c_s1),
		.wdata (pn),
		.re    (acc),
		.raddr (c0),
		.rdata (ptr_rdata)
	);

	cbdi_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (SD),
		.AW    (SAW)
	) u_store_ram (
		.clk   (clk),
		.we    (st_acc),
		.waddr (st_addr),
		.wdata (dat_s1),
		.re    (st_acc),
		.raddr (st_addr),
		.rdata (st_rdata)
	);

	always_comb begin
		beat.vld = v_s2;
		if (!nz_s2) begin
			beat.dat = dat_s2;
		end else begin
			beat.dat = fill_s2 ? st_rdata : '0;
		end
	end

`ifndef SYNTH
	a_ptr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		st_acc |-> (p < len_s1))
		else $error("branch pointer beyond branch length");
	a_comm_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> (c_s1 <= CW'(BRANCHES - 1)))
		else $error("commutator beyond last branch");
	a_len_matches: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && c_s1 == CW'(BRANCHES - 1)) |-> (len_s1 == '0))
		else $error("last branch has nonzero length");
`endif

endmodule
`default_nettype wire

@@ sv/cbdi_align.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cbdi_align - fixed alignment delay line
// Circular buffer in RAM; a full flag stands in for the cleared contents.
// With zero depth the byte passes through one register.
// ----------------------------------------------------------------------------
module cbdi_align #(
	parameter int ALIGN_DEPTH = cbdi_pkg::ALIGN_DEPTH_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire cbdi_pkg::cbdi_beat_t in_beat,
	output cbdi_pkg::cbdi_beat_t      out_beat
);
	import cbdi_pkg::*;

	generate
		if (ALIGN_DEPTH == 0) begin : g_bypass
			logic              v_s3;
			logic [BYTE_W-1:0] dat_s3;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_s3 <= 1'b0;
				end else begin
					v_s3 <= in_beat.vld;
				end
			end

			always_ff @(posedge clk) begin
				dat_s3 <= in_beat.dat;
			end

			assign out_beat.vld = v_s3;
			assign out_beat.dat = dat_s3;
		end else begin : g_line
			localparam int AAW = (ALIGN_DEPTH > 1) ? $clog2(ALIGN_DEPTH) : 1;

			logic [AAW-1:0]    ap_q;
			logic              full_q;
			logic              v_s3;
			logic              full_s3;
			logic [BYTE_W-1:0] rdata;

			// advance the pointer, mark full after the first wrap
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					ap_q   <= '0;
					full_q <= 1'b0;
					v_s3   <= 1'b0;
				end else begin
					v_s3 <= in_beat.vld;
					if (in_beat.vld) begin
						if (ap_q == AAW'(ALIGN_DEPTH - 1)) begin
							ap_q   <= '0;
							full_q <= 1'b1;
						end else begin
							ap_q <= AAW'(ap_q + AAW'(1));
						end
					end
				end
			end

			always_ff @(posedge clk) begin
				full_s3 <= full_q;
			end

			cbdi_ram #(
				.WIDTH (BYTE_W),
				.DEPTH (ALIGN_DEPTH),
				.AW    (AAW)
			) u_align_ram (
				.clk   (clk),
				.we    (in_beat.vld),
				.waddr (ap_q),
				.wdata (in_beat.dat),
				.re    (in_beat.vld),
				.raddr (ap_q),
				.rdata (rdata)
			);

			assign out_beat.vld = v_s3;
			assign out_beat.dat = full_s3 ? rdata : '0;
		end
	endgenerate

endmodule
`default_nettype wire

@@ sv/cbdi_outq.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cbdi_outq - output queue with credit-based intake
// Counts every byte from its intake to its delivery and stalls intake when
// the queue could not hold all bytes in flight.
// ----------------------------------------------------------------------------
module cbdi_outq #(
	parameter int DEPTH = cbdi_pkg::OUTQ_DEPTH_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        acc,
	output logic                             in_stall,
	input  wire cbdi_pkg::cbdi_beat_t        push,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic [cbdi_pkg::BYTE_W-1:0]      out_data
);
	import cbdi_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int OW = $clog2(DEPTH + 1);

	logic [BYTE_W-1:0] q_mem [DEPTH];
	logic [PW-1:0]     wp_q;
	logic [PW-1:0]     rp_q;
	logic [OW-1:0]     cnt_q;
	logic [OW-1:0]     occ_q;
	logic              pop;

	assign out_valid = (cnt_q != '0);
	assign out_data  = q_mem[rp_q];
	assign pop       = out_valid && !out_stall;
	assign in_stall  = (occ_q == OW'(DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
			occ_q <= '0;
		end else begin
			if (push.vld) begin
				wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : PW'(wp_q + PW'(1));
			end
			if (pop) begin
				rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : PW'(rp_q + PW'(1));
			end
			cnt_q <= OW'(cnt_q + OW'(push.vld) - OW'(pop));
			occ_q <= OW'(occ_q + OW'(acc) - OW'(pop));
		end
	end

	always_ff @(posedge clk) begin
		if (push.vld) begin
			q_mem[wp_q] <= push.dat;
		end
	end

`ifndef SYNTH
	a_cnt_le_occ: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= occ_q)
		else $error("queue holds more bytes than are in flight");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push.vld && !pop) |-> (cnt_q != OW'(DEPTH)))
		else $error("push into full output queue");
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OW'(DEPTH))
		else $error("intake credit exceeded");
`endif

endmodule
`default_nettype wire

@@ sv/convolutional_byte_deinterleaver.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// convolutional_byte_deinterleaver - 52-branch convolutional byte deinterleaver
// Commutated branch delay lines in RAM, a fixed alignment delay line, and an
// output queue.
// ----------------------------------------------------------------------------
// One byte in, one byte out, one transfer per cycle sustained without result
// stall. A commutator walks the branches; branch i delays its bytes by
// (BRANCHES-1-i)*DELAY_STEP visits, the last branch passes its byte straight
// on. Every branch output then goes through a fixed delay of ALIGN_DEPTH bytes.
// Raise resync with a byte to send that byte to branch 0; delay line contents
// and pointers stay as they are. All delay lines read as zero until written,
// so the block takes bytes from the first cycle after reset with no clearing
// pass. A byte passes pointer RAM read, branch store read, alignment RAM read
// and output queue on its way out. Each RAM is read and written at most once
// per byte, so the RAM ports set the rate of one byte per cycle. Under result
// stall the output queue of OUTQ_DEPTH bytes absorbs the bytes in flight;
// intake stalls once all of them are taken up.
// ----------------------------------------------------------------------------
module convolutional_byte_deinterleaver #(
	parameter int BRANCHES    = cbdi_pkg::BRANCHES_DEF,
	parameter int DELAY_STEP  = cbdi_pkg::DELAY_STEP_DEF,
	parameter int ALIGN_DEPTH = cbdi_pkg::ALIGN_DEPTH_DEF,
	parameter int OUTQ_DEPTH  = cbdi_pkg::OUTQ_DEPTH_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        item_valid,
	output logic                             item_stall,
	input  wire logic [cbdi_pkg::BYTE_W-1:0] data_in,
	input  wire logic                        resync,
	output logic                             result_valid,
	input  wire logic                        result_stall,
	output logic      [cbdi_pkg::BYTE_W-1:0] data_out
);
	import cbdi_pkg::*;

	logic       acc;
	cbdi_beat_t br_beat;
	cbdi_beat_t al_beat;

	// take the byte on a completed input transfer
	assign acc = item_valid && !item_stall;

	// commutator, branch pointers and branch delay lines
	cbdi_branch #(
		.BRANCHES   (BRANCHES),
		.DELAY_STEP (DELAY_STEP)
	) u_branch (
		.clk     (clk),
		.arst_n  (arst_n),
		.acc     (acc),
		.data_in (data_in),
		.resync  (resync),
		.beat    (br_beat)
	);

	// fixed alignment delay after every branch
	cbdi_align #(
		.ALIGN_DEPTH (ALIGN_DEPTH)
	) u_align (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_beat  (br_beat),
		.out_beat (al_beat)
	);

	// hold results until the consumer takes them, throttle intake by credit
	cbdi_outq #(
		.DEPTH (OUTQ_DEPTH)
	) u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.acc       (acc),
		.in_stall  (item_stall),
		.push      (al_beat),
		.out_valid (result_valid),
		.out_stall (result_stall),
		.out_data  (data_out)
	);

endmodule
`default_nettype wire
